FILE: hw/rtl/ds_twr_pkg.sv
// Package for the double-sided two-way ranging initiator.
// Holds the phase and calculator state types, frame codes and result codes.
// No dependencies.
package ds_twr_pkg;

	typedef enum logic [2:0] {
		PH_IDLE      = 3'd0,
		PH_TX_INIT   = 3'd1,
		PH_WAIT_ACK  = 3'd2,
		PH_TX_RESP   = 3'd3,
		PH_WAIT_LAST = 3'd4
	} phase_t;

	typedef enum logic [2:0] {
		C_IDLE = 3'd0,
		C_MUL1 = 3'd1,
		C_MUL2 = 3'd2,
		C_DIFF = 3'd3,
		C_MUL3 = 3'd4,
		C_DIV  = 3'd5,
		C_DONE = 3'd6
	} calc_t;

	localparam logic [1:0] OP_START  = 2'd0;
	localparam logic [1:0] OP_TXDONE = 2'd1;
	localparam logic [1:0] OP_RX     = 2'd2;

	localparam logic [1:0] KIND_TX     = 2'd0;
	localparam logic [1:0] KIND_RESULT = 2'd1;
	localparam logic [1:0] KIND_FAIL   = 2'd2;

	localparam logic [2:0] FAIL_NONE = 3'd0;
	localparam logic [2:0] FAIL_RX   = 3'd1;
	localparam logic [2:0] FAIL_LEN  = 3'd2;
	localparam logic [2:0] FAIL_HDR  = 3'd3;
	localparam logic [2:0] FAIL_DEN  = 3'd4;

	localparam logic [0:0] TX_INIT_FRAME = 1'b0;
	localparam logic [0:0] TX_RESP_FRAME = 1'b1;

	localparam logic [0:0] REG_OWN_ADDRESS = 1'b0;
	localparam logic [0:0] REG_MM_PER_TICK = 1'b1;

	localparam logic [7:0] LETTER_ACK  = 8'h41;
	localparam logic [7:0] LETTER_LAST = 8'h4C;
	localparam logic [6:0] LEN_ACK     = 7'd8;
	localparam logic [6:0] LEN_LAST    = 7'd16;

	localparam logic [15:0] OWN_ADDRESS_RST = 16'h8913;
	localparam logic [23:0] MM_PER_TICK_RST = 24'd307396;

endpackage

FILE: hw/rtl/ds_twr_initiator.sv
// Top level of the double-sided two-way ranging initiator.
// Frame checks, phase tracking and a bit-serial multiply/divide distance unit.
// Depends on ds_twr_pkg.
//
// channel   direction  handshake               payload
// s_*       in         s_tvalid / s_tready      tuser operation, tdata event fields
// m_*       out        m_tvalid / m_tready      tuser kind, tdata result fields
// cfg_*     in         cfg_valid / cfg_ready    cfg_index, cfg_data
//
// A last frame runs to a valid result through two 32-step shift-add products,
// a compare step, a 24-step scaling product, an 88-step restoring division
// and a final step that loads the result once the output is free.
// s_tready is low while the distance unit runs or a result waits unaccepted.
// Reset puts the exchange in idle and reloads the default registers.
module ds_twr_initiator (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         s_tvalid,
	output logic         s_tready,
	// start_dest, timestamp, rx_good, frame_length, src_address,
	// dst_address, msg_letter, msg_seq, remote_reply, remote_round
	input  logic [167:0] s_tdata,
	// operation
	input  logic [1:0]   s_tuser,
	output logic         m_tvalid,
	input  logic         m_tready,
	// tx_type, tx_dest, tx_seq, distance_mm, fail_code, rx_reset_request, zero pad
	output logic [63:0]  m_tdata,
	// kind
	output logic [1:0]   m_tuser,
	input  logic         cfg_valid,
	output logic         cfg_ready,
	input  logic [0:0]   cfg_index,
	input  logic [23:0]  cfg_data
);
	import ds_twr_pkg::*;

	logic [15:0] in_dest, in_src, in_dst;
	logic [31:0] in_ts, in_da, in_ra;
	logic        in_good;
	logic [6:0]  in_len;
	logic [7:0]  in_letter, in_seq;

	assign in_dest   = s_tdata[15:0];
	assign in_ts     = s_tdata[47:16];
	assign in_good   = s_tdata[48];
	assign in_len    = s_tdata[55:49];
	assign in_src    = s_tdata[71:56];
	assign in_dst    = s_tdata[87:72];
	assign in_letter = s_tdata[95:88];
	assign in_seq    = s_tdata[103:96];
	assign in_da     = s_tdata[135:104];
	assign in_ra     = s_tdata[167:136];

	logic [15:0] own_address_q;
	logic [23:0] mm_per_tick_q;
	phase_t      phase_q, phase_d;
	logic [15:0] peer_q;
	logic [7:0]  seq_q;
	logic [31:0] last_stamp_q, round_q, reply_q;

	calc_t       state_q, state_d;
	logic [6:0]  cnt_q;
	logic [87:0] acc_q, mcand_q;
	logic [31:0] mplier_q, da_q;
	logic [63:0] p1_q;
	logic [33:0] den_q, rem_q;
	logic        neg_q, big_q;

	logic        out_valid_q;
	logic [1:0]  out_kind_q;
	logic [63:0] out_data_q;

	logic        out_free, accept, start_calc, out_load;
	logic [1:0]  load_kind;
	logic        load_type;
	logic [15:0] load_dest;
	logic [7:0]  load_seq, cur_seq;
	logic [31:0] load_dist;
	logic [2:0]  load_code, chk_code;
	logic [6:0]  exp_len;
	logic [7:0]  exp_letter;
	logic [33:0] den_in;
	logic [87:0] mul_sum;
	logic [34:0] rem_sh;
	logic        div_ge;
	logic [63:0] mag;
	logic        p_lt;
	logic [71:0] qd;
	logic [31:0] calc_dist;

	assign cfg_ready = 1'b1;
	assign out_free  = !out_valid_q || m_tready;
	assign s_tready  = (state_q == C_IDLE) && out_free;
	assign accept    = s_tvalid && s_tready;
	assign cur_seq   = seq_q - 8'd1;

	assign m_tvalid = out_valid_q;
	assign m_tuser  = out_kind_q;
	assign m_tdata  = out_data_q;

	assign exp_len    = (phase_q == PH_WAIT_ACK) ? LEN_ACK : LEN_LAST;
	assign exp_letter = (phase_q == PH_WAIT_ACK) ? LETTER_ACK : LETTER_LAST;
	assign den_in     = {2'b00, in_ra} + {2'b00, in_da} + {2'b00, round_q} + {2'b00, reply_q};

	always_comb begin
		priority if (!in_good) begin
			chk_code = FAIL_RX;
		end else if (in_len != exp_len) begin
			chk_code = FAIL_LEN;
		end else if (in_src != peer_q || in_dst != own_address_q ||
				in_letter != exp_letter || in_seq != cur_seq) begin
			chk_code = FAIL_HDR;
		end else begin
			chk_code = FAIL_NONE;
		end
	end

	assign mul_sum = mplier_q[0] ? acc_q + mcand_q : acc_q;
	assign rem_sh  = {rem_q, acc_q[87]};
	assign div_ge  = rem_sh >= {1'b0, den_q};
	assign p_lt    = p1_q < acc_q[63:0];
	assign mag     = p_lt ? acc_q[63:0] - p1_q : p1_q - acc_q[63:0];
	assign qd      = acc_q[87:16];

	always_comb begin
		if (big_q) begin
			calc_dist = neg_q ? 32'h8000_0000 : 32'h7FFF_FFFF;
		end else if (neg_q) begin
			calc_dist = (qd > 72'h8000_0000) ? 32'h8000_0000 : 32'd0 - qd[31:0];
		end else begin
			calc_dist = (qd > 72'h7FFF_FFFF) ? 32'h7FFF_FFFF : qd[31:0];
		end
	end

	always_comb begin
		phase_d    = phase_q;
		start_calc = 1'b0;
		out_load   = 1'b0;
		load_kind  = KIND_TX;
		load_type  = TX_INIT_FRAME;
		load_dest  = 16'd0;
		load_seq   = 8'd0;
		load_dist  = 32'd0;
		load_code  = FAIL_NONE;
		if (state_q == C_DONE && out_free) begin
			phase_d   = PH_IDLE;
			out_load  = 1'b1;
			load_kind = KIND_RESULT;
			load_dist = calc_dist;
		end else if (accept) begin
			unique case (s_tuser)
				OP_START: begin
					if (phase_q == PH_IDLE) begin
						phase_d   = PH_TX_INIT;
						out_load  = 1'b1;
						load_dest = in_dest;
						load_seq  = seq_q;
					end
				end
				OP_TXDONE: begin
					if (phase_q == PH_TX_INIT) begin
						phase_d = PH_WAIT_ACK;
					end else if (phase_q == PH_TX_RESP) begin
						phase_d = PH_WAIT_LAST;
					end
				end
				OP_RX: begin
					if (phase_q == PH_WAIT_ACK || phase_q == PH_WAIT_LAST) begin
						out_load = 1'b1;
						if (chk_code != FAIL_NONE) begin
							phase_d   = PH_IDLE;
							load_kind = KIND_FAIL;
							load_code = chk_code;
						end else if (phase_q == PH_WAIT_ACK) begin
							phase_d   = PH_TX_RESP;
							load_type = TX_RESP_FRAME;
							load_dest = peer_q;
							load_seq  = cur_seq;
						end else if (den_in == 34'd0) begin
							phase_d   = PH_IDLE;
							load_kind = KIND_FAIL;
							load_code = FAIL_DEN;
						end else begin
							out_load   = 1'b0;
							start_calc = 1'b1;
						end
					end
				end
				default: begin
				end
			endcase
		end
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			C_IDLE: if (start_calc) state_d = C_MUL1;
			C_MUL1: if (cnt_q == 7'd31) state_d = C_MUL2;
			C_MUL2: if (cnt_q == 7'd31) state_d = C_DIFF;
			C_DIFF: state_d = C_MUL3;
			C_MUL3: if (cnt_q == 7'd23) state_d = C_DIV;
			C_DIV:  if (cnt_q == 7'd87) state_d = C_DONE;
			C_DONE: if (out_free) state_d = C_IDLE;
			default: state_d = C_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= C_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			own_address_q <= OWN_ADDRESS_RST;
			mm_per_tick_q <= MM_PER_TICK_RST;
			phase_q       <= PH_IDLE;
			peer_q        <= 16'd0;
			seq_q         <= 8'd0;
			last_stamp_q  <= 32'd0;
			round_q       <= 32'd0;
			reply_q       <= 32'd0;
			out_valid_q   <= 1'b0;
		end else begin
			if (cfg_valid) begin
				unique case (cfg_index)
					REG_OWN_ADDRESS: own_address_q <= cfg_data[15:0];
					REG_MM_PER_TICK: mm_per_tick_q <= cfg_data;
					default: begin
					end
				endcase
			end
			phase_q <= phase_d;
			if (accept && s_tuser == OP_START && phase_q == PH_IDLE) begin
				peer_q <= in_dest;
				seq_q  <= seq_q + 8'd1;
			end
			if (accept && s_tuser == OP_TXDONE) begin
				if (phase_q == PH_TX_INIT) begin
					last_stamp_q <= in_ts;
				end else if (phase_q == PH_TX_RESP) begin
					reply_q <= in_ts - last_stamp_q;
				end
			end
			if (accept && s_tuser == OP_RX && phase_q == PH_WAIT_ACK &&
					chk_code == FAIL_NONE) begin
				round_q      <= in_ts - last_stamp_q;
				last_stamp_q <= in_ts;
			end
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (m_tready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			out_kind_q <= load_kind;
			out_data_q <= {3'b000, load_code == FAIL_RX, load_code, load_dist,
				load_seq, load_dest, load_type};
		end
		unique case (state_q)
			C_IDLE: begin
				if (start_calc) begin
					acc_q    <= 88'd0;
					mcand_q  <= {56'd0, in_ra};
					mplier_q <= round_q;
					da_q     <= in_da;
					den_q    <= den_in;
					cnt_q    <= 7'd0;
				end
			end
			C_MUL1, C_MUL2, C_MUL3: begin
				if (state_q == C_MUL1 && cnt_q == 7'd31) begin
					p1_q     <= mul_sum[63:0];
					acc_q    <= 88'd0;
					mcand_q  <= {56'd0, da_q};
					mplier_q <= reply_q;
					cnt_q    <= 7'd0;
				end else begin
					acc_q    <= mul_sum;
					mcand_q  <= {mcand_q[86:0], 1'b0};
					mplier_q <= {1'b0, mplier_q[31:1]};
					if (state_q == C_MUL3 && cnt_q == 7'd23) begin
						rem_q <= 34'd0;
						cnt_q <= 7'd0;
					end else begin
						cnt_q <= cnt_q + 7'd1;
					end
				end
			end
			C_DIFF: begin
				neg_q    <= p_lt;
				big_q    <= (mm_per_tick_q != 24'd0) && ({10'd0, mag[63:40]} >= den_q);
				acc_q    <= 88'd0;
				mcand_q  <= {24'd0, mag};
				mplier_q <= {8'd0, mm_per_tick_q};
				cnt_q    <= 7'd0;
			end
			C_DIV: begin
				rem_q <= div_ge ? rem_sh[33:0] - den_q : rem_sh[33:0];
				acc_q <= {acc_q[86:0], div_ge};
				cnt_q <= cnt_q + 7'd1;
			end
			C_DONE: begin
			end
			default: begin
			end
		endcase
	end

endmodule

FILE: hw/rtl/ds_twr_checker.sv
// Port-level checker for the ranging initiator, bound to the top level.
// Depends on ds_twr_pkg and ds_twr_initiator.
module ds_twr_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        m_tvalid,
	input logic        m_tready,
	input logic [63:0] m_tdata,
	input logic [1:0]  m_tuser
);
	import ds_twr_pkg::*;

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
		else $error("result changed while stalled");

	a_kind: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> m_tuser == KIND_TX || m_tuser == KIND_RESULT || m_tuser == KIND_FAIL)
		else $error("bad result kind");

	a_rst: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser == KIND_FAIL |->
			m_tdata[60] == (m_tdata[59:57] == FAIL_RX) && m_tdata[59:57] != FAIL_NONE)
		else $error("receiver reset request does not match failure");

	a_result: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser == KIND_RESULT |-> m_tdata[24:0] == 25'd0 && m_tdata[63:57] == 7'd0)
		else $error("ranging result carries stray fields");

endmodule

bind ds_twr_initiator ds_twr_checker u_ds_twr_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata),
	.m_tuser  (m_tuser)
);

FILE: tb/ds_twr_initiator_tb.sv
// Self-checking testbench for the two-way ranging initiator.
// Drives event requests and config writes, predicts results in-bench; needs ds_twr_pkg.
`timescale 1ns / 1ps
module ds_twr_initiator_tb;
	import ds_twr_pkg::*;

	typedef struct packed {
		logic [1:0]  op;
		logic [15:0] dest;
		logic [31:0] ts;
		logic        good;
		logic [6:0]  len;
		logic [15:0] src;
		logic [15:0] dst;
		logic [7:0]  letter;
		logic [7:0]  seq;
		logic [31:0] da;
		logic [31:0] ra;
	} ranging_event_t;

	typedef struct packed {
		logic [1:0]  kind;
		logic        tx_type;
		logic [15:0] tx_dest;
		logic [7:0]  tx_seq;
		logic [31:0] dist_mm;
		logic [2:0]  code;
		logic        rst_req;
	} ranging_out_t;

	typedef struct {
		ranging_event_t ev;
		bit             typed;
		bit             fires;
		ranging_out_t   res;
	} table_row_t;

	localparam int WATCHDOG_LIMIT = 20000;
	localparam int DRAIN_CYCLES   = 250;
	localparam int RANDOM_ITEMS   = 1400;
	localparam int STALL_CYCLES   = 3000;

	logic         clk, arst_n;
	logic         s_tvalid, s_tready;
	logic [167:0] s_tdata;
	logic [1:0]   s_tuser;
	logic         m_tvalid, m_tready;
	logic [63:0]  m_tdata;
	logic [1:0]   m_tuser;
	logic         cfg_valid, cfg_ready;
	logic [0:0]   cfg_index;
	logic [23:0]  cfg_data;

	ds_twr_initiator dut (.*);

	phase_t       ph;
	logic [15:0]  own_addr, peer_addr;
	logic [23:0]  mm_q16;
	logic [7:0]   nxt_seq;
	logic [31:0]  last_ts, round_iv, reply_iv, drv_ts;
	ranging_out_t pending_q[$];
	int           errors;
	int           idle_cycles;
	bit           stall_req;
	table_row_t   rows[$];

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	function automatic ranging_event_t mk_ev(logic [1:0] op, logic [15:0] dest, logic [31:0] ts,
			logic good, logic [6:0] len, logic [15:0] src, logic [15:0] dst, logic [7:0] letter,
			logic [7:0] seq, logic [31:0] da, logic [31:0] ra);
		ranging_event_t e;
		e = '{op, dest, ts, good, len, src, dst, letter, seq, da, ra};
		return e;
	endfunction

	function automatic ranging_out_t mk_res(logic [1:0] kind, logic tt, logic [15:0] dest,
			logic [7:0] seq, logic [2:0] code);
		ranging_out_t r;
		r = '{kind, tt, dest, seq, 32'd0, code, code == FAIL_RX};
		return r;
	endfunction

	function automatic logic [2:0] frame_fault(ranging_event_t e, logic [6:0] len, logic [7:0] l);
		if (!e.good) return FAIL_RX;
		if (e.len != len) return FAIL_LEN;
		if (e.src != peer_addr || e.dst != own_addr || e.letter != l || e.seq != nxt_seq - 8'd1)
			return FAIL_HDR;
		return FAIL_NONE;
	endfunction

	task automatic predict_event(input ranging_event_t e, output bit fire, output ranging_out_t r);
		logic [63:0] p1, p2, mag, den, q, rm, t, d;
		logic [2:0]  c;
		bit          neg;
		fire = 1'b0;
		r = '0;
		case (e.op)
			OP_START: if (ph == PH_IDLE) begin
				peer_addr = e.dest;
				r = mk_res(KIND_TX, TX_INIT_FRAME, peer_addr, nxt_seq, FAIL_NONE);
				nxt_seq = nxt_seq + 8'd1;
				ph = PH_TX_INIT;
				fire = 1'b1;
			end
			OP_TXDONE: if (ph == PH_TX_INIT) begin
				last_ts = e.ts;
				ph = PH_WAIT_ACK;
			end else if (ph == PH_TX_RESP) begin
				reply_iv = e.ts - last_ts;
				ph = PH_WAIT_LAST;
			end
			OP_RX: if (ph == PH_WAIT_ACK) begin
				fire = 1'b1;
				c = frame_fault(e, LEN_ACK, LETTER_ACK);
				if (c != FAIL_NONE) begin
					r = mk_res(KIND_FAIL, 1'b0, 16'd0, 8'd0, c);
					ph = PH_IDLE;
				end else begin
					round_iv = e.ts - last_ts;
					last_ts = e.ts;
					ph = PH_TX_RESP;
					r = mk_res(KIND_TX, TX_RESP_FRAME, peer_addr, nxt_seq - 8'd1, FAIL_NONE);
				end
			end else if (ph == PH_WAIT_LAST) begin
				fire = 1'b1;
				c = frame_fault(e, LEN_LAST, LETTER_LAST);
				p1 = 64'(e.ra) * 64'(round_iv);
				p2 = 64'(e.da) * 64'(reply_iv);
				neg = p1 < p2;
				mag = neg ? p2 - p1 : p1 - p2;
				den = 64'(e.ra) + 64'(e.da) + 64'(round_iv) + 64'(reply_iv);
				if (c == FAIL_NONE && den == 64'd0) c = FAIL_DEN;
				ph = PH_IDLE;
				if (c != FAIL_NONE) begin
					r = mk_res(KIND_FAIL, 1'b0, 16'd0, 8'd0, c);
				end else begin
					q = mag / den;
					rm = mag % den;
					if (mm_q16 != 24'd0 && q >= (64'd1 << 40)) begin
						d = 64'd1 << 40;
					end else begin
						t = q * 64'(mm_q16) + (rm * 64'(mm_q16)) / den;
						d = t >> 16;
					end
					r = mk_res(KIND_RESULT, 1'b0, 16'd0, 8'd0, FAIL_NONE);
					if (neg) begin
						if (d > 64'h8000_0000) d = 64'h8000_0000;
						r.dist_mm = 32'd0 - d[31:0];
					end else begin
						if (d > 64'h7FFF_FFFF) d = 64'h7FFF_FFFF;
						r.dist_mm = d[31:0];
					end
				end
			end
			default: ;
		endcase
	endtask

	task automatic send_event(input ranging_event_t e, input bit typed, input bit fires,
			input ranging_out_t exp_res);
		bit           fire;
		ranging_out_t r;
		int           gap;
		@(negedge clk);
		s_tvalid = 1'b1;
		s_tuser = e.op;
		s_tdata = {e.ra, e.da, e.seq, e.letter, e.dst, e.src, e.len, e.good, e.ts, e.dest};
		do @(posedge clk); while (!s_tready);
		predict_event(e, fire, r);
		if (typed) begin
			if (fires) pending_q.push_back(exp_res);
		end else if (fire) begin
			pending_q.push_back(r);
		end
		case ($urandom_range(0, 19))
			0: gap = $urandom_range(10, 40);
			1, 2, 3, 4, 5: gap = $urandom_range(1, 3);
			default: gap = 0;
		endcase
		if (gap > 0) begin
			@(negedge clk);
			s_tvalid = 1'b0;
			repeat (gap - 1) @(negedge clk);
		end
	endtask

	task automatic write_reg(input logic [0:0] idx, input logic [23:0] val);
		@(negedge clk);
		cfg_valid = 1'b1;
		cfg_index = idx;
		cfg_data = val;
		do @(posedge clk); while (!cfg_ready);
		if (idx == REG_OWN_ADDRESS) own_addr = val[15:0];
		else mm_q16 = val;
		@(negedge clk);
		cfg_valid = 1'b0;
	endtask

	task automatic wait_drained();
		@(negedge clk);
		s_tvalid = 1'b0;
		while (pending_q.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	function automatic ranging_event_t next_random_event();
		ranging_event_t e;
		logic [31:0]    dts;
		e = mk_ev(2'($urandom_range(0, 3)), 16'($urandom), $urandom,
			1'($urandom_range(0, 1)), 7'($urandom_range(0, 127)), 16'($urandom),
			16'($urandom), 8'($urandom), 8'($urandom), $urandom, $urandom);
		if ($urandom_range(0, 99) < 15) return e;
		dts = ($urandom_range(0, 3) == 0) ? 32'($urandom) : 32'($urandom_range(0, 5000));
		drv_ts = drv_ts + dts;
		e.ts = drv_ts;
		case (ph)
			PH_IDLE: e.op = OP_START;
			PH_TX_INIT, PH_TX_RESP: e.op = OP_TXDONE;
			default: begin
				e.op = OP_RX;
				e.good = 1'b1;
				e.len = (ph == PH_WAIT_ACK) ? LEN_ACK : LEN_LAST;
				e.src = peer_addr;
				e.dst = own_addr;
				e.letter = (ph == PH_WAIT_ACK) ? LETTER_ACK : LETTER_LAST;
				e.seq = nxt_seq - 8'd1;
				if ($urandom_range(0, 1) == 0) begin
					e.da = $urandom_range(0, 20000);
					e.ra = $urandom_range(0, 20000);
				end
				case ($urandom_range(0, 19))
					0: e.good = 1'b0;
					1: e.len = 7'($urandom_range(0, 127));
					2: e.src = 16'($urandom);
					3: e.dst = 16'($urandom);
					4: e.letter = 8'($urandom);
					5: e.seq = 8'($urandom);
					default: ;
				endcase
			end
		endcase
		return e;
	endfunction

	always @(posedge clk) begin
		ranging_out_t got, want;
		if (m_tvalid && m_tready) begin
			got = '{m_tuser, m_tdata[0], m_tdata[16:1], m_tdata[24:17], m_tdata[56:25],
				m_tdata[59:57], m_tdata[60]};
			if (pending_q.size() == 0) begin
				$error("unexpected result kind=%0d", got.kind);
				errors++;
			end else begin
				want = pending_q.pop_front();
				if (got.kind != want.kind) begin
					$error("kind: expected %0d, got %0d", want.kind, got.kind); errors++;
				end
				if (got.tx_type != want.tx_type) begin
					$error("tx_type: expected %0d, got %0d", want.tx_type, got.tx_type); errors++;
				end
				if (got.tx_dest != want.tx_dest) begin
					$error("tx_dest: expected %h, got %h", want.tx_dest, got.tx_dest); errors++;
				end
				if (got.tx_seq != want.tx_seq) begin
					$error("tx_seq: expected %0d, got %0d", want.tx_seq, got.tx_seq); errors++;
				end
				if (got.dist_mm != want.dist_mm) begin
					$error("distance_mm: expected %0d, got %0d", $signed(want.dist_mm),
						$signed(got.dist_mm));
					errors++;
				end
				if (got.code != want.code) begin
					$error("fail_code: expected %0d, got %0d", want.code, got.code); errors++;
				end
				if (got.rst_req != want.rst_req) begin
					$error("rx_reset_request: expected %0d, got %0d", want.rst_req,
						got.rst_req);
					errors++;
				end
			end
		end
	end

	initial begin
		m_tready = 1'b0;
		forever begin
			@(negedge clk);
			if (stall_req) begin
				m_tready = 1'b0;
				repeat (STALL_CYCLES) @(negedge clk);
				stall_req = 1'b0;
			end else begin
				case ($urandom_range(0, 19))
					0: begin
						m_tready = 1'b0;
						repeat ($urandom_range(10, 40)) @(negedge clk);
					end
					1, 2, 3, 4: m_tready = 1'b0;
					default: m_tready = 1'b1;
				endcase
			end
		end
	end

	always @(posedge clk) begin
		if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= WATCHDOG_LIMIT) begin
			$display("simulation failed");
			$finish;
		end
	end

	initial begin
		ranging_out_t none;
		none = '0;
		stall_req = 1'b0;
		arst_n = 1'b0;
		s_tvalid = 1'b0;
		s_tdata = '0;
		s_tuser = '0;
		cfg_valid = 1'b0;
		cfg_index = '0;
		cfg_data = '0;
		ph = PH_IDLE;
		own_addr = OWN_ADDRESS_RST;
		mm_q16 = MM_PER_TICK_RST;
		peer_addr = '0;
		nxt_seq = '0;
		last_ts = '0;
		round_iv = '0;
		reply_iv = '0;
		drv_ts = '0;

		rows = '{
			'{mk_ev(2'd3, 0, 0, 1, LEN_ACK, 0, 16'h8913, LETTER_ACK, 0, 0, 0), 1, 0, none},
			'{mk_ev(OP_TXDONE, 0, 5, 0, 0, 0, 0, 0, 0, 0, 0), 1, 0, none},
			'{mk_ev(OP_RX, 0, 5, 1, LEN_ACK, 0, 16'h8913, LETTER_ACK, 8'hFF, 0, 0), 1, 0, none},
			'{mk_ev(OP_START, 16'h1234, 0, 0, 0, 0, 0, 0, 0, 0, 0), 1, 1,
				mk_res(KIND_TX, TX_INIT_FRAME, 16'h1234, 8'd0, FAIL_NONE)},
			'{mk_ev(OP_START, 16'h5555, 0, 0, 0, 0, 0, 0, 0, 0, 0), 1, 0, none},
			'{mk_ev(OP_TXDONE, 0, 100, 0, 0, 0, 0, 0, 0, 0, 0), 1, 0, none},
			'{mk_ev(OP_RX, 0, 200, 0, LEN_ACK, 16'h1234, 16'h8913, LETTER_ACK, 0, 0, 0), 1, 1,
				mk_res(KIND_FAIL, 1'b0, 16'd0, 8'd0, FAIL_RX)},
			'{mk_ev(OP_START, 16'hFFFF, 0, 0, 0, 0, 0, 0, 0, 0, 0), 1, 1,
				mk_res(KIND_TX, TX_INIT_FRAME, 16'hFFFF, 8'd1, FAIL_NONE)},
			'{mk_ev(OP_TXDONE, 0, 32'hFFFF_FFF0, 0, 0, 0, 0, 0, 0, 0, 0), 1, 0, none},
			'{mk_ev(OP_RX, 0, 32, 1, LEN_LAST, 16'hFFFF, 16'h8913, LETTER_ACK, 1, 0, 0), 1, 1,
				mk_res(KIND_FAIL, 1'b0, 16'd0, 8'd0, FAIL_LEN)},
			'{mk_ev(OP_START, 16'h0000, 0, 0, 0, 0, 0, 0, 0, 0, 0), 1, 1,
				mk_res(KIND_TX, TX_INIT_FRAME, 16'h0000, 8'd2, FAIL_NONE)},
			'{mk_ev(OP_TXDONE, 0, 5, 0, 0, 0, 0, 0, 0, 0, 0), 1, 0, none},
			'{mk_ev(OP_RX, 0, 9, 1, LEN_ACK, 0, 16'h8913, LETTER_ACK, 1, 0, 0), 1, 1,
				mk_res(KIND_FAIL, 1'b0, 16'd0, 8'd0, FAIL_HDR)},
			'{mk_ev(OP_START, 16'h0000, 0, 0, 0, 0, 0, 0, 0, 0, 0), 1, 1,
				mk_res(KIND_TX, TX_INIT_FRAME, 16'h0000, 8'd3, FAIL_NONE)},
			'{mk_ev(OP_TXDONE, 0, 7, 0, 0, 0, 0, 0, 0, 0, 0), 1, 0, none},
			'{mk_ev(OP_RX, 0, 7, 1, LEN_ACK, 0, 16'h8913, LETTER_ACK, 3, 0, 0), 1, 1,
				mk_res(KIND_TX, TX_RESP_FRAME, 16'h0000, 8'd3, FAIL_NONE)},
			'{mk_ev(OP_TXDONE, 0, 7, 0, 0, 0, 0, 0, 0, 0, 0), 1, 0, none},
			'{mk_ev(OP_RX, 0, 7, 1, LEN_LAST, 0, 16'h8913, LETTER_LAST, 3, 0, 0), 1, 1,
				mk_res(KIND_FAIL, 1'b0, 16'd0, 8'd0, FAIL_DEN)},
			'{mk_ev(OP_START, 16'hABCD, 0, 0, 0, 0, 0, 0, 0, 0, 0), 1, 1,
				mk_res(KIND_TX, TX_INIT_FRAME, 16'hABCD, 8'd4, FAIL_NONE)},
			'{mk_ev(OP_TXDONE, 0, 32'hFFFF_FF00, 0, 0, 0, 0, 0, 0, 0, 0), 1, 0, none},
			'{mk_ev(OP_RX, 0, 32'h100, 1, LEN_ACK, 16'hABCD, 16'h8913, LETTER_ACK, 4, 0, 0),
				1, 1, mk_res(KIND_TX, TX_RESP_FRAME, 16'hABCD, 8'd4, FAIL_NONE)},
			'{mk_ev(OP_TXDONE, 0, 32'h200, 0, 0, 0, 0, 0, 0, 0, 0), 1, 0, none},
			'{mk_ev(OP_RX, 0, 32'h300, 1, LEN_LAST, 16'hABCD, 16'h8913, LETTER_LAST, 4,
				32'h0, 32'hFFFF_FFFF), 0, 0, none},
			'{mk_ev(OP_START, 16'h00FF, 0, 0, 0, 0, 0, 0, 0, 0, 0), 0, 0, none},
			'{mk_ev(OP_TXDONE, 0, 32'h0, 0, 0, 0, 0, 0, 0, 0, 0), 0, 0, none},
			'{mk_ev(OP_RX, 0, 32'h10, 1, LEN_ACK, 16'h00FF, 16'h8913, LETTER_ACK, 5, 0, 0),
				0, 0, none},
			'{mk_ev(OP_TXDONE, 0, 32'h7FFF_FFFF, 0, 0, 0, 0, 0, 0, 0, 0), 0, 0, none},
			'{mk_ev(OP_RX, 0, 32'h8000_0000, 1, LEN_LAST, 16'h00FF, 16'h8913, LETTER_LAST, 5,
				32'hFFFF_FFFF, 32'h0), 0, 0, none}
		};

		repeat (8) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		foreach (rows[i]) send_event(rows[i].ev, rows[i].typed, rows[i].fires, rows[i].res);

		for (int n = 0; n < RANDOM_ITEMS; n++) begin
			if (n % 350 == 0) begin
				wait_drained();
				case (n / 350)
					0: begin write_reg(REG_OWN_ADDRESS, 24'h0000); write_reg(REG_MM_PER_TICK, 0); end
					1: begin
						write_reg(REG_OWN_ADDRESS, 24'hFFFF);
						write_reg(REG_MM_PER_TICK, 24'hFF_FFFF);
					end
					2: begin
						write_reg(REG_OWN_ADDRESS, 24'($urandom_range(0, 65535)));
						write_reg(REG_MM_PER_TICK, 24'($urandom_range(0, 24'hFF_FFFF)));
					end
					default: begin
						write_reg(REG_OWN_ADDRESS, OWN_ADDRESS_RST);
						write_reg(REG_MM_PER_TICK, MM_PER_TICK_RST);
					end
				endcase
			end
			if (n == 500) stall_req = 1'b1;
			send_event(next_random_event(), 1'b0, 1'b0, none);
		end

		wait_drained();
		if (errors == 0)
			$display("simulation ok");
		else
			$display("simulation failed");
		$finish;
	end
endmodule
